### hdl/dfa_word_acceptor_top_defines.svh
// assertion macros for the dfa word acceptor
`ifndef DFA_WORD_ACCEPTOR_TOP_DEFINES_SVH
`define DFA_WORD_ACCEPTOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DFAWA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: never");
`define DFAWA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define DFAWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");
`else
`define DFAWA_ASSERT_NEVER(lbl, expr)
`define DFAWA_ASSERT_IMPLY(lbl, ante, cons)
`define DFAWA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/dfawa_pkg.sv
// shared constants and controller/datapath interface types
package dfawa_pkg;

  parameter int NUM_STATES_DEF  = 16;
  parameter int SYMBOL_BITS_DEF = 8;

  parameter int OPCODE_W = 2;
  parameter int STIDX_W  = 4;
  parameter int SYMBOL_W = 8;

  localparam logic [OPCODE_W-1:0] OP_TRANS_WR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FLAG_WR  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SYMBOL   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_EMPTY_Q  = 2'd3;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic step;
    logic out_load;
  } dfawa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_symbol;
    logic is_query;
    logic last;
    logic out_free;
  } dfawa_sts_t;

endpackage

### hdl/dfawa_ctrl.sv
// controller state machine: table clear, accept, lookup step, result hand-off
module dfawa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dfawa_pkg::dfawa_sts_t sts,
  output dfawa_pkg::dfawa_cmd_t cmd
);
  import dfawa_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.is_symbol) state_nxt = S_STEP;
          else if (sts.is_query) state_nxt = S_OUT;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = sts.last ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

### hdl/dfawa_dp.sv
// datapath: transition memory, accepting flags, word state and result register
module dfawa_dp #(
  parameter int NUM_STATES  = dfawa_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_BITS = dfawa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [dfawa_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [dfawa_pkg::STIDX_W-1:0]    in_state_index,
  input  logic [dfawa_pkg::SYMBOL_W-1:0]   in_symbol_code,
  input  logic [dfawa_pkg::STIDX_W-1:0]    in_target_state,
  input  logic                             in_entry_valid,
  input  logic                             in_final_flag,
  input  logic                             in_last_symbol,
  input  logic                             cfg_we,
  input  logic [dfawa_pkg::STIDX_W-1:0]    cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_accepted,
  output logic                             out_stuck,
  input  dfawa_pkg::dfawa_cmd_t            cmd,
  output dfawa_pkg::dfawa_sts_t            sts
);
  import dfawa_pkg::*;

  localparam int STATE_W     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int ADDR_W      = STATE_W + SYMBOL_BITS;
  localparam int ENT_W       = STATE_W + 1;
  localparam int MEM_DEPTH   = 1 << ADDR_W;
  localparam int NUM_SYMBOLS = 1 << SYMBOL_BITS;
  localparam logic [8:0] NS_LIM  = 9'(NUM_STATES);
  localparam logic [8:0] SYM_LIM = 9'(NUM_SYMBOLS);

  logic [ENT_W-1:0] mem [MEM_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [NUM_STATES-1:0] flags_r;
  logic [STIDX_W-1:0] init_r;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic dead_r, dead_nxt;
  logic in_word_r, in_word_nxt;
  logic skip_r, skip_nxt;
  logic last_r, last_nxt;
  logic res_acc_r, res_acc_nxt;
  logic res_stuck_r, res_stuck_nxt;
  logic out_valid_r, out_acc_r, out_stuck_r;

  logic st_ok, tgt_ok, sym_ok, init_ok;
  logic [STATE_W-1:0] init_st, cur_eff, rd_tgt, cur_new;
  logic dead_new, rd_valid, start;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [ENT_W-1:0] wr_data;

  assign st_ok   = ({5'd0, in_state_index} < NS_LIM);
  assign tgt_ok  = ({5'd0, in_target_state} < NS_LIM);
  assign sym_ok  = ({1'b0, in_symbol_code} < SYM_LIM);
  assign init_ok = ({5'd0, init_r} < NS_LIM);
  assign init_st = STATE_W'(init_r);

  assign start   = !in_word_r;
  assign cur_eff = start ? init_st : cur_r;
  assign rd_addr = {cur_eff, in_symbol_code[SYMBOL_BITS-1:0]};
  assign wr_addr = cmd.clr_wr ? clr_cnt_r
                              : {STATE_W'(in_state_index), in_symbol_code[SYMBOL_BITS-1:0]};
  assign wr_data = cmd.clr_wr ? '0 : {in_entry_valid, STATE_W'(in_target_state)};
  assign wr_en   = cmd.clr_wr
                 || (cmd.accept && (in_opcode == OP_TRANS_WR) && st_ok && tgt_ok && sym_ok);

  // transition memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.accept && (in_opcode == OP_SYMBOL)) rd_data_r <= mem[rd_addr];
  end

  assign rd_valid = rd_data_r[ENT_W-1];
  assign rd_tgt   = rd_data_r[STATE_W-1:0];
  assign dead_new = skip_r || !rd_valid;
  assign cur_new  = dead_new ? cur_r : rd_tgt;

  always_comb begin
    cur_nxt       = cur_r;
    dead_nxt      = dead_r;
    in_word_nxt   = in_word_r;
    skip_nxt      = skip_r;
    last_nxt      = last_r;
    res_acc_nxt   = res_acc_r;
    res_stuck_nxt = res_stuck_r;
    if (cmd.accept && (in_opcode == OP_SYMBOL)) begin
      cur_nxt     = cur_eff;
      skip_nxt    = (start ? !init_ok : dead_r) || !sym_ok;
      last_nxt    = in_last_symbol;
      in_word_nxt = 1'b1;
    end else if (cmd.accept && (in_opcode == OP_EMPTY_Q)) begin
      res_acc_nxt   = init_ok && flags_r[init_st];
      res_stuck_nxt = 1'b0;
    end else if (cmd.step) begin
      if (last_r) begin
        res_acc_nxt   = !dead_new && flags_r[cur_new];
        res_stuck_nxt = dead_new;
        in_word_nxt   = 1'b0;
        dead_nxt      = 1'b0;
      end else begin
        cur_nxt  = cur_new;
        dead_nxt = dead_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      flags_r     <= '0;
      init_r      <= '0;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      in_word_r   <= 1'b0;
      skip_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_we) init_r <= cfg_data;
      if (cmd.accept && (in_opcode == OP_FLAG_WR) && st_ok)
        flags_r[STATE_W'(in_state_index)] <= in_final_flag;
      cur_r     <= cur_nxt;
      dead_r    <= dead_nxt;
      in_word_r <= in_word_nxt;
      skip_r    <= skip_nxt;
      last_r    <= last_nxt;
      if (cmd.out_load)    out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_acc_r   <= res_acc_nxt;
    res_stuck_r <= res_stuck_nxt;
    if (cmd.out_load) begin
      out_acc_r   <= res_acc_r;
      out_stuck_r <= res_stuck_r;
    end
  end

  assign sts.clr_done  = (clr_cnt_r == {ADDR_W{1'b1}});
  assign sts.is_symbol = (in_opcode == OP_SYMBOL);
  assign sts.is_query  = (in_opcode == OP_EMPTY_Q);
  assign sts.last      = last_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_stuck    = out_stuck_r;

endmodule

### hdl/dfa_word_acceptor_top.sv
// top level of the table-driven dfa word acceptor
// load beats (transition or flag write) do not stall the input; a word symbol stalls it through
// the registered transition-memory read and the next-state update, and on the last symbol
// until the result beat is loaded, as does an empty-word query; a stalled result adds its stall
// a new symbol is taken only once the previous one's memory read has fed the next address
// after reset a clearing pass over all 1<<(STATE_W+SYMBOL_BITS) table entries (4096) stalls the input
`include "dfa_word_acceptor_top_defines.svh"
module dfa_word_acceptor_top #(
  parameter int NUM_STATES  = dfawa_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_BITS = dfawa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dfawa_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [dfawa_pkg::STIDX_W-1:0]  in_state_index,
  input  logic [dfawa_pkg::SYMBOL_W-1:0] in_symbol_code,
  input  logic [dfawa_pkg::STIDX_W-1:0]  in_target_state,
  input  logic                           in_entry_valid,
  input  logic                           in_final_flag,
  input  logic                           in_last_symbol,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic                           out_stuck,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfawa_pkg::STIDX_W-1:0]  cfg_data
);
  import dfawa_pkg::*;

  dfawa_cmd_t cmd;
  dfawa_sts_t sts;

  assign cfg_ready = 1'b1;

  dfawa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfawa_dp #(
    .NUM_STATES  (NUM_STATES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_state_index  (in_state_index),
    .in_symbol_code  (in_symbol_code),
    .in_target_state (in_target_state),
    .in_entry_valid  (in_entry_valid),
    .in_final_flag   (in_final_flag),
    .in_last_symbol  (in_last_symbol),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_stuck       (out_stuck),
    .cmd             (cmd),
    .sts             (sts)
  );

  `DFAWA_ASSERT_NEVER(a_no_accept_in_clear, cmd.accept && cmd.clr_wr)
  `DFAWA_ASSERT_IMPLY(a_load_only_when_free, cmd.out_load, sts.out_free)
  `DFAWA_ASSERT_NEXT(a_symbol_then_step, cmd.accept && sts.is_symbol, cmd.step && in_stall)
  `DFAWA_ASSERT_IMPLY(a_stuck_never_accepted, out_valid && out_stuck, !out_accepted)

endmodule

### tb/sv/dfa_verdict_checker.sv
// checker for the dfa word acceptor: tracks the automaton and scores every result beat
module dfa_verdict_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [dfawa_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [dfawa_pkg::STIDX_W-1:0]  in_state_index,
  input  logic [dfawa_pkg::SYMBOL_W-1:0] in_symbol_code,
  input  logic [dfawa_pkg::STIDX_W-1:0]  in_target_state,
  input  logic                           in_entry_valid,
  input  logic                           in_final_flag,
  input  logic                           in_last_symbol,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_accepted,
  input  logic                           out_stuck,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dfawa_pkg::STIDX_W-1:0]  cfg_data,
  output int                             fail_count,
  output int                             pending_verdicts
);
  import dfawa_pkg::*;

  localparam int TABLE_DEPTH = NUM_STATES_DEF << SYMBOL_BITS_DEF;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic accepted;
    logic stuck;
  } verdict_t;

  // valid mark on top, next state below
  logic [STIDX_W:0]   next_state_mem [TABLE_DEPTH];
  logic               accepting [NUM_STATES_DEF];
  logic [STIDX_W-1:0] start_state;
  logic [STIDX_W-1:0] walk_state;
  logic               word_dead;
  logic               in_word;
  verdict_t           expected_verdicts [$];

  initial begin
    fail_count       = 0;
    pending_verdicts = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    fail_count++;
  endtask

  task automatic step_automaton(
    input logic [OPCODE_W-1:0] op,
    input logic [STIDX_W-1:0]  st,
    input logic [SYMBOL_W-1:0] sym,
    input logic [STIDX_W-1:0]  tgt,
    input logic                ev,
    input logic                ff,
    input logic                last
  );
    logic [STIDX_W:0] entry;
    verdict_t         v;
    case (op)
      OP_TRANS_WR: begin
        next_state_mem[{st, sym}] = {ev, tgt};
      end
      OP_FLAG_WR: begin
        accepting[st] = ff;
      end
      OP_EMPTY_Q: begin
        v.accepted = accepting[start_state];
        v.stuck    = 1'b0;
        expected_verdicts.insert(expected_verdicts.size(), v);
      end
      default: begin
        if (!in_word) begin
          walk_state = start_state;
          word_dead  = 1'b0;
          in_word    = 1'b1;
        end
        if (!word_dead) begin
          entry = next_state_mem[{walk_state, sym}];
          if (entry[STIDX_W]) begin
            walk_state = entry[STIDX_W-1:0];
          end else begin
            word_dead = 1'b1;
          end
        end
        if (last) begin
          v.accepted = !word_dead && accepting[walk_state];
          v.stuck    = word_dead;
          expected_verdicts.insert(expected_verdicts.size(), v);
          in_word   = 1'b0;
          word_dead = 1'b0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      foreach (next_state_mem[i]) next_state_mem[i] = '0;
      foreach (accepting[i]) accepting[i] = 1'b0;
      start_state = '0;
      walk_state  = '0;
      word_dead   = 1'b0;
      in_word     = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_state = cfg_data;
      end
      if (in_valid && !in_stall) begin
        step_automaton(in_opcode, in_state_index, in_symbol_code, in_target_state,
                       in_entry_valid, in_final_flag, in_last_symbol);
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result beat with no verdict pending");
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (out_accepted !== exp_v.accepted) begin
            report_mismatch($sformatf("accepted %b, expected %b", out_accepted, exp_v.accepted));
          end
          if (out_stuck !== exp_v.stuck) begin
            report_mismatch($sformatf("stuck %b, expected %b", out_stuck, exp_v.stuck));
          end
        end
      end
    end
    pending_verdicts <= expected_verdicts.size();
  end

endmodule

### tb/sv/dfa_word_acceptor_top_tb.sv
// testbench top for the dfa word acceptor: reset, stimulus, stall patterns and verdict
module dfa_word_acceptor_top_tb;
  import dfawa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_ITEMS    = 230;
  localparam int ALPHABET_SIZE  = 4;
  localparam int MAX_WORD_LEN   = 10;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode       = OP_EMPTY_Q;
  logic [STIDX_W-1:0]  in_state_index  = '0;
  logic [SYMBOL_W-1:0] in_symbol_code  = '0;
  logic [STIDX_W-1:0]  in_target_state = '0;
  logic                in_entry_valid  = 1'b0;
  logic                in_final_flag   = 1'b0;
  logic                in_last_symbol  = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic                out_accepted;
  logic                out_stuck;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [STIDX_W-1:0]  cfg_data        = '0;
  int                  fail_count;
  int                  pending_verdicts;
  int                  hold_reqs       = 0;
  int                  idle_cycles     = 0;
  int                  burst_left      = 0;
  logic [SYMBOL_W-1:0] alphabet [ALPHABET_SIZE];

  always #10 clk = ~clk;

  dfa_word_acceptor_top u_top (.*);

  dfa_verdict_checker u_checker (.*);

  function automatic logic [STIDX_W-1:0] rand_state();
    return STIDX_W'($urandom_range(0, NUM_STATES_DEF - 1));
  endfunction

  function automatic logic [SYMBOL_W-1:0] rand_symbol();
    return SYMBOL_W'($urandom_range(0, (1 << SYMBOL_W) - 1));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_beat(
    input logic [OPCODE_W-1:0] op,
    input logic [STIDX_W-1:0]  st,
    input logic [SYMBOL_W-1:0] sym,
    input logic [STIDX_W-1:0]  tgt,
    input logic                ev,
    input logic                ff,
    input logic                last
  );
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(20, 80);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_state_index  <= st;
    in_symbol_code  <= sym;
    in_target_state <= tgt;
    in_entry_valid  <= ev;
    in_final_flag   <= ff;
    in_last_symbol  <= last;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_verdicts != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_state(input logic [STIDX_W-1:0] st);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= st;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int phase);
    logic [STIDX_W-1:0]  st0;
    logic [SYMBOL_W-1:0] sym;
    logic                last;
    logic                open_word;
    int                  word_len;
    int                  r;
    if (phase == 0) begin
      st0 = STIDX_W'(NUM_STATES_DEF - 1);
    end else if (phase == 1) begin
      st0 = '0;
    end else begin
      st0 = rand_state();
    end
    write_start_state(st0);
    foreach (alphabet[a]) alphabet[a] = rand_symbol();
    // mostly complete table over a small alphabet so words run deep
    for (int s = 0; s < NUM_STATES_DEF; s++) begin
      foreach (alphabet[a]) begin
        send_beat(OP_TRANS_WR, STIDX_W'(s), alphabet[a], rand_state(),
                  1'($urandom_range(0, 9) < 8), rand_bit(), rand_bit());
      end
    end
    for (int s = 0; s < NUM_STATES_DEF; s++) begin
      send_beat(OP_FLAG_WR, STIDX_W'(s), rand_symbol(), rand_state(), rand_bit(), rand_bit(),
                rand_bit());
    end
    open_word = 1'b0;
    word_len  = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (phase == 2 && n == 40) begin
        hold_reqs <= hold_reqs + 1;
      end
      r = $urandom_range(0, 99);
      if (r < (open_word ? 80 : 60)) begin
        sym = ($urandom_range(0, 99) < 92) ? alphabet[$urandom_range(0, ALPHABET_SIZE - 1)]
                                           : rand_symbol();
        word_len++;
        last = ($urandom_range(0, 3) == 0) || (word_len >= MAX_WORD_LEN);
        send_beat(OP_SYMBOL, rand_state(), sym, rand_state(), rand_bit(), rand_bit(), last);
        open_word = !last;
        if (last) begin
          word_len = 0;
        end
      end else if (r < (open_word ? 88 : 75)) begin
        sym = ($urandom_range(0, 99) < 70) ? alphabet[$urandom_range(0, ALPHABET_SIZE - 1)]
                                           : rand_symbol();
        send_beat(OP_TRANS_WR, rand_state(), sym, rand_state(),
                  1'($urandom_range(0, 3) != 0), rand_bit(), rand_bit());
      end else if (r < (open_word ? 94 : 85)) begin
        send_beat(OP_FLAG_WR, rand_state(), rand_symbol(), rand_state(), rand_bit(), rand_bit(),
                  rand_bit());
      end else begin
        send_beat(OP_EMPTY_Q, rand_state(), rand_symbol(), rand_state(), rand_bit(), rand_bit(),
                  rand_bit());
      end
    end
    if (open_word) begin
      send_beat(OP_SYMBOL, rand_state(), alphabet[0], rand_state(), rand_bit(), rand_bit(), 1'b1);
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty word straight after reset, then with the start state accepting
    send_beat(OP_EMPTY_Q,  4'd0,  8'd0,   4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_FLAG_WR,  4'd0,  8'd255, 4'd15, 1'b1, 1'b1, 1'b1);
    send_beat(OP_EMPTY_Q,  4'd15, 8'd255, 4'd15, 1'b1, 1'b1, 1'b1);
    // empty table: one-symbol word gets stuck
    send_beat(OP_SYMBOL,   4'd15, 8'd0,   4'd15, 1'b1, 1'b1, 1'b1);
    send_beat(OP_TRANS_WR, 4'd0,  8'd255, 4'd15, 1'b1, 1'b0, 1'b0);
    send_beat(OP_TRANS_WR, 4'd15, 8'd0,   4'd0,  1'b1, 1'b0, 1'b0);
    send_beat(OP_FLAG_WR,  4'd15, 8'd0,   4'd0,  1'b0, 1'b1, 1'b0);
    send_beat(OP_SYMBOL,   4'd0,  8'd255, 4'd0,  1'b0, 1'b0, 1'b1);
    send_beat(OP_SYMBOL,   4'd0,  8'd255, 4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_SYMBOL,   4'd0,  8'd0,   4'd0,  1'b0, 1'b0, 1'b1);
    // dead word ignores the rest of its symbols
    send_beat(OP_SYMBOL,   4'd0,  8'd0,   4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_SYMBOL,   4'd0,  8'd255, 4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_SYMBOL,   4'd0,  8'd255, 4'd0,  1'b0, 1'b0, 1'b1);
    // query and loads inside a word
    send_beat(OP_SYMBOL,   4'd0,  8'd255, 4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_EMPTY_Q,  4'd0,  8'd0,   4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_FLAG_WR,  4'd15, 8'd0,   4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_SYMBOL,   4'd0,  8'd0,   4'd0,  1'b0, 1'b0, 1'b1);
    send_beat(OP_SYMBOL,   4'd0,  8'd255, 4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_TRANS_WR, 4'd15, 8'd0,   4'd0,  1'b0, 1'b0, 1'b0);
    send_beat(OP_SYMBOL,   4'd0,  8'd0,   4'd0,  1'b0, 1'b0, 1'b1);
    // start state change does not touch the word in progress
    send_beat(OP_TRANS_WR, 4'd0,  8'd128, 4'd3,  1'b1, 1'b0, 1'b0);
    send_beat(OP_SYMBOL,   4'd0,  8'd128, 4'd0,  1'b0, 1'b0, 1'b0);
    write_start_state(4'd15);
    send_beat(OP_SYMBOL,   4'd0,  8'd255, 4'd0,  1'b0, 1'b0, 1'b1);
    send_beat(OP_EMPTY_Q,  4'd0,  8'd0,   4'd0,  1'b0, 1'b0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(p);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_verdicts == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : result_stall
    int mode;
    int left;
    int seen_holds;
    mode       = 0;
    left       = 0;
    seen_holds = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen_holds) begin
        // long hold-off so the block backs up into its input
        seen_holds = hold_reqs;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= rand_bit();
          2: out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= (left % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
